### rtl/corner_kalman_tracker_macros.svh
// Assertion macros used by the bound checker file.
`ifndef CORNER_KALMAN_TRACKER_MACROS_SVH
`define CORNER_KALMAN_TRACKER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CKT_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("corner tracker check failed");

// The consequent must hold in the cycle after the antecedent.
`define CKT_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("corner tracker check failed");

`endif

### rtl/ckt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ckt_pkg;

   localparam int NUM_CORNERS_DEF = 4;

   localparam int CMD_W   = 2;
   localparam int MEAS_W  = 16;
   localparam int EST_W   = 20;
   localparam int POS_W   = 21;
   localparam int CFG_W   = 24;
   localparam int CSR_IDX_W = 2;
   localparam int DIAG_W  = 24;
   localparam int OFF_W   = 25;
   localparam int SUM_W   = DIAG_W + 1;
   localparam int FRAC_W  = 16;
   localparam int KP_W    = FRAC_W + 1;
   localparam int KV_W    = 32;
   localparam int DVD_W   = OFF_W + FRAC_W;
   localparam int WIDE_W  = 64;

   localparam logic [DVD_W-1:0] GAIN_LIM = DVD_W'(64'd1 << 30);

   localparam logic [CSR_IDX_W-1:0] REG_PROCESS_NOISE     = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_MEASUREMENT_NOISE = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_INITIAL_ERROR     = CSR_IDX_W'(2);

   localparam logic [CFG_W-1:0] PROCESS_NOISE_RST     = CFG_W'(3277);
   localparam logic [CFG_W-1:0] MEASUREMENT_NOISE_RST = CFG_W'(52429);
   localparam logic [CFG_W-1:0] INITIAL_ERROR_RST     = CFG_W'(65536);

   localparam logic signed [WIDE_W-1:0] RND_HALF = WIDE_W'(64'sd1 <<< (FRAC_W - 1));
   localparam logic signed [WIDE_W-1:0] POS_HI = (64'sd1 <<< (POS_W - 1)) - 64'sd1;
   localparam logic signed [WIDE_W-1:0] POS_LO = -(64'sd1 <<< (POS_W - 1));
   localparam logic signed [WIDE_W-1:0] EST_HI = (64'sd1 <<< (EST_W - 1)) - 64'sd1;
   localparam logic signed [WIDE_W-1:0] EST_LO = -(64'sd1 <<< (EST_W - 1));
   localparam logic signed [WIDE_W-1:0] DIAG_HI = (64'sd1 <<< DIAG_W) - 64'sd1;
   localparam logic signed [WIDE_W-1:0] OFF_HI = (64'sd1 <<< (OFF_W - 1)) - 64'sd1;
   localparam logic signed [WIDE_W-1:0] OFF_LO = -(64'sd1 <<< (OFF_W - 1));

   typedef enum logic [CMD_W-1:0] {
      CMD_MEASURE = 2'd0,
      CMD_PREDICT = 2'd1,
      CMD_RESET   = 2'd2
   } cmd_type;

   typedef struct packed {
      logic init;
      logic predict;
      logic mul;
      logic correct;
   } step_type;

   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] c;
      c = (v > POS_HI) ? POS_HI : ((v < POS_LO) ? POS_LO : v);
      return c[POS_W-1:0];
   endfunction

   function automatic logic signed [EST_W-1:0] sat_est(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] c;
      c = (v > EST_HI) ? EST_HI : ((v < EST_LO) ? EST_LO : v);
      return c[EST_W-1:0];
   endfunction

   function automatic logic [DIAG_W-1:0] sat_diag(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] c;
      c = (v > DIAG_HI) ? DIAG_HI : ((v < 64'sd0) ? 64'sd0 : v);
      return c[DIAG_W-1:0];
   endfunction

   function automatic logic signed [OFF_W-1:0] sat_off(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] c;
      c = (v > OFF_HI) ? OFF_HI : ((v < OFF_LO) ? OFF_LO : v);
      return c[OFF_W-1:0];
   endfunction

endpackage
`default_nettype wire

### rtl/ckt_lane.sv
`timescale 1ns / 1ps
`default_nettype none
module ckt_lane (
   input  wire logic                                clock,
   input  wire ckt_pkg::step_type                   step,
   input  wire logic [ckt_pkg::MEAS_W-1:0]          meas,
   input  wire logic [ckt_pkg::KP_W-1:0]            kp,
   input  wire logic signed [ckt_pkg::KV_W-1:0]     kv,
   output logic signed [ckt_pkg::POS_W-1:0]         pos
);
   import ckt_pkg::*;

   localparam int E_W  = POS_W + 1;
   localparam int PP_W = KP_W + 1 + E_W;
   localparam int PV_W = KV_W + E_W;

   logic signed [POS_W-1:0] pos_ff, pos_in, vel_ff, vel_in;
   logic signed [PP_W-1:0]  prod_p_ff, prod_p_in;
   logic signed [PV_W-1:0]  prod_v_ff, prod_v_in;
   logic signed [E_W-1:0]   err;

   always_comb begin
      err = $signed({{(E_W - MEAS_W){1'b0}}, meas}) - $signed({pos_ff[POS_W-1], pos_ff});
      pos_in = pos_ff;
      vel_in = vel_ff;
      prod_p_in = prod_p_ff;
      prod_v_in = prod_v_ff;
      if (step.init) begin
         pos_in = $signed({{(POS_W - MEAS_W){1'b0}}, meas});
         vel_in = '0;
      end else if (step.predict) begin
         pos_in = sat_pos(WIDE_W'(pos_ff) + WIDE_W'(vel_ff));
      end else if (step.mul) begin
         prod_p_in = $signed({1'b0, kp}) * err;
         prod_v_in = kv * err;
      end else if (step.correct) begin
         pos_in = sat_pos(WIDE_W'(pos_ff) + ((WIDE_W'(prod_p_ff) + RND_HALF) >>> FRAC_W));
         vel_in = sat_pos(WIDE_W'(vel_ff) + ((WIDE_W'(prod_v_ff) + RND_HALF) >>> FRAC_W));
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      vel_ff <= vel_in;
      prod_p_ff <= prod_p_in;
      prod_v_ff <= prod_v_in;
   end

   assign pos = pos_ff;

endmodule
`default_nettype wire

### rtl/ckt_cov.sv
`timescale 1ns / 1ps
`default_nettype none
module ckt_cov (
   input  wire logic                                clock,
   input  wire ckt_pkg::step_type                   step,
   input  wire logic [ckt_pkg::CFG_W-1:0]           process_noise,
   input  wire logic [ckt_pkg::CFG_W-1:0]           measurement_noise,
   input  wire logic [ckt_pkg::CFG_W-1:0]           initial_error,
   input  wire logic [ckt_pkg::KP_W-1:0]            kp,
   input  wire logic signed [ckt_pkg::KV_W-1:0]     kv,
   output logic [ckt_pkg::DIAG_W-1:0]               ppp,
   output logic signed [ckt_pkg::OFF_W-1:0]         ppv,
   output logic [ckt_pkg::SUM_W-1:0]                innov
);
   import ckt_pkg::*;

   localparam int PA_W = KP_W + 1 + DIAG_W + 1;
   localparam int PB_W = KP_W + 1 + OFF_W;
   localparam int PC_W = KV_W + OFF_W;

   logic [DIAG_W-1:0]       ppp_ff, ppp_in, pvv_ff, pvv_in;
   logic signed [OFF_W-1:0] ppv_ff, ppv_in;
   logic signed [PA_W-1:0]  pa_ff, pa_in;
   logic signed [PB_W-1:0]  pb_ff, pb_in;
   logic signed [PC_W-1:0]  pc_ff, pc_in;
   logic signed [WIDE_W-1:0] ppp_w, pvv_w, ppv_w, q_w;

   always_comb begin
      ppp_w = WIDE_W'($signed({1'b0, ppp_ff}));
      pvv_w = WIDE_W'($signed({1'b0, pvv_ff}));
      ppv_w = WIDE_W'(ppv_ff);
      q_w   = WIDE_W'($signed({1'b0, process_noise}));
      ppp_in = ppp_ff;
      ppv_in = ppv_ff;
      pvv_in = pvv_ff;
      pa_in = pa_ff;
      pb_in = pb_ff;
      pc_in = pc_ff;
      if (step.init) begin
         ppp_in = initial_error;
         ppv_in = '0;
         pvv_in = initial_error;
      end else if (step.predict) begin
         ppp_in = sat_diag(ppp_w + (ppv_w <<< 1) + pvv_w + q_w);
         ppv_in = sat_off(ppv_w + pvv_w);
         pvv_in = sat_diag(pvv_w + q_w);
      end else if (step.mul) begin
         pa_in = $signed({1'b0, kp}) * $signed({1'b0, ppp_ff});
         pb_in = $signed({1'b0, kp}) * ppv_ff;
         pc_in = kv * ppv_ff;
      end else if (step.correct) begin
         ppp_in = sat_diag(ppp_w - ((WIDE_W'(pa_ff) + RND_HALF) >>> FRAC_W));
         ppv_in = sat_off(ppv_w - ((WIDE_W'(pb_ff) + RND_HALF) >>> FRAC_W));
         pvv_in = sat_diag(pvv_w - ((WIDE_W'(pc_ff) + RND_HALF) >>> FRAC_W));
      end
   end

   always_ff @(posedge clock) begin
      ppp_ff <= ppp_in;
      ppv_ff <= ppv_in;
      pvv_ff <= pvv_in;
      pa_ff <= pa_in;
      pb_ff <= pb_in;
      pc_ff <= pc_in;
   end

   assign ppp   = ppp_ff;
   assign ppv   = ppv_ff;
   assign innov = {1'b0, ppp_ff} + {1'b0, measurement_noise};

endmodule
`default_nettype wire

### rtl/ckt_div.sv
`timescale 1ns / 1ps
`default_nettype none
module ckt_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [ckt_pkg::DVD_W-1:0]     dividend,
   input  wire logic [ckt_pkg::SUM_W-1:0]     divisor,
   output logic [ckt_pkg::DVD_W-1:0]          quotient,
   output logic                               busy
);
   import ckt_pkg::*;

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [DVD_W-1:0] dvd_ff, dvd_in, quo_ff, quo_in;
   logic [SUM_W-1:0] rem_ff, rem_in, div_ff, div_in;
   logic [SUM_W:0]   rem_sh, rem_nx;
   logic             fits;

   always_comb begin
      rem_sh = {rem_ff, dvd_ff[DVD_W-1]};
      fits = rem_sh >= {1'b0, div_ff};
      rem_nx = fits ? (rem_sh - {1'b0, div_ff}) : rem_sh;
      count_in = count_ff;
      dvd_in = dvd_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      if (start) begin
         count_in = CNT_W'(DVD_W);
         dvd_in = dividend;
         quo_in = '0;
         rem_in = '0;
         div_in = divisor;
      end else if (count_ff != '0) begin
         count_in = count_ff - CNT_W'(1);
         dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         quo_in = {quo_ff[DVD_W-2:0], fits};
         rem_in = rem_nx[SUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign quotient = quo_ff;
   assign busy = count_ff != '0;

endmodule
`default_nettype wire

### rtl/corner_kalman_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Payload
// req_      in         tdata: measured x/y per corner; tuser: command
// rsp_      out        tdata: estimated x/y per corner; tuser: estimate valid
// csr_      in         write enable, register index, write data
//
// A measure request runs predict, divider start, two gain dividers side by side at one
// quotient bit a cycle, a gain load, multiply, correct and output; one that starts a
// track runs an init step first. Predict while tracking runs only the predict step
// and the other commands go straight to output. One request is in work at a time.
// Reset clears tracking and the result valid flag. A stalled result holds the block
// before its output stage until it is taken.
module corner_kalman_tracker #(
   parameter int NUM_CORNERS = ckt_pkg::NUM_CORNERS_DEF
) (
   input  wire logic                                          clock,
   input  wire logic                                          reset,
   input  wire logic                                          req_tvalid,
   output logic                                               req_tready,
   // meas_x0, meas_y0, meas_x1, meas_y1, ... from the lowest bit up
   input  wire logic [2*NUM_CORNERS*ckt_pkg::MEAS_W-1:0]      req_tdata,
   // command
   input  wire logic [ckt_pkg::CMD_W-1:0]                     req_tuser,
   output logic                                               rsp_tvalid,
   input  wire logic                                          rsp_tready,
   // est_x0, est_y0, est_x1, est_y1, ... from the lowest bit up
   output logic [2*NUM_CORNERS*ckt_pkg::EST_W-1:0]            rsp_tdata,
   // est_valid
   output logic                                               rsp_tuser,
   input  wire logic                                          csr_we,
   input  wire logic [ckt_pkg::CSR_IDX_W-1:0]                 csr_index,
   input  wire logic [ckt_pkg::CFG_W-1:0]                     csr_wdata
);
   import ckt_pkg::*;

   localparam int LANES = 2 * NUM_CORNERS;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_INIT = 7'b0000010,
      ST_PRED = 7'b0000100,
      ST_SDIV = 7'b0001000,
      ST_DIV  = 7'b0010000,
      ST_MUL  = 7'b0100000,
      ST_CORR = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic emit_ff, emit_in;
   logic meas_cmd_ff, meas_cmd_in;
   logic tracking_ff, tracking_in;
   logic [LANES*MEAS_W-1:0] meas_ff, meas_in;
   logic [CFG_W-1:0] pn_ff, pn_in, mn_ff, mn_in, ie_ff, ie_in;
   logic [KP_W-1:0] kp_ff, kp_in;
   logic signed [KV_W-1:0] kv_ff, kv_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_user_ff, rsp_user_in;
   logic [LANES*EST_W-1:0] rsp_data_ff, rsp_data_in, est_all;
   step_type step;
   logic div_start, busy_p, busy_v;
   logic [DIAG_W-1:0] ppp;
   logic signed [OFF_W-1:0] ppv;
   logic [SUM_W-1:0] innov;
   logic [OFF_W-1:0] mag_v;
   logic [DVD_W-1:0] dvd_p, dvd_v, quo_p, quo_v, cap_v;
   logic signed [KV_W-1:0] kv_mag;
   logic signed [POS_W-1:0] pos_w [LANES];

   always_comb begin
      mag_v = ppv[OFF_W-1] ? $unsigned(-ppv) : $unsigned(ppv);
      dvd_p = DVD_W'({ppp, {FRAC_W{1'b0}}}) + DVD_W'(innov[SUM_W-1:1]);
      dvd_v = DVD_W'({mag_v, {FRAC_W{1'b0}}}) + DVD_W'(innov[SUM_W-1:1]);
      cap_v = (quo_v > GAIN_LIM) ? GAIN_LIM : quo_v;
      kv_mag = $signed(KV_W'(cap_v));
   end

   ckt_div u_div_p (
      .clock(clock), .reset(reset), .start(div_start), .dividend(dvd_p),
      .divisor(innov), .quotient(quo_p), .busy(busy_p)
   );

   ckt_div u_div_v (
      .clock(clock), .reset(reset), .start(div_start), .dividend(dvd_v),
      .divisor(innov), .quotient(quo_v), .busy(busy_v)
   );

   ckt_cov u_cov (
      .clock(clock), .step(step), .process_noise(pn_ff), .measurement_noise(mn_ff),
      .initial_error(ie_ff), .kp(kp_ff), .kv(kv_ff), .ppp(ppp), .ppv(ppv),
      .innov(innov)
   );

   for (genvar j = 0; j < LANES; j++) begin : g_lane
      ckt_lane u_lane (
         .clock(clock), .step(step), .meas(meas_ff[j*MEAS_W +: MEAS_W]),
         .kp(kp_ff), .kv(kv_ff), .pos(pos_w[j])
      );
      assign est_all[j*EST_W +: EST_W] =
         tracking_ff ? sat_est(WIDE_W'(pos_w[j])) : '0;
   end

   always_comb begin
      state_in = state_ff;
      emit_in = emit_ff;
      meas_cmd_in = meas_cmd_ff;
      tracking_in = tracking_ff;
      meas_in = meas_ff;
      kp_in = kp_ff;
      kv_in = kv_ff;
      step = '0;
      div_start = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_user_in = rsp_user_ff;
      rsp_data_in = rsp_data_ff;
      pn_in = pn_ff;
      mn_in = mn_ff;
      ie_in = ie_ff;
      if (csr_we) begin
         case (csr_index)
            REG_PROCESS_NOISE:     pn_in = csr_wdata;
            REG_MEASUREMENT_NOISE: mn_in = csr_wdata;
            REG_INITIAL_ERROR:     ie_in = csr_wdata;
            default: ;
         endcase
      end
      if (emit_ff) begin
         if (!rsp_valid_ff || rsp_tready) begin
            rsp_valid_in = 1'b1;
            rsp_user_in = tracking_ff;
            rsp_data_in = est_all;
            emit_in = 1'b0;
            state_in = ST_IDLE;
         end
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  meas_in = req_tdata;
                  meas_cmd_in = 1'b0;
                  case (req_tuser)
                     CMD_MEASURE: begin
                        meas_cmd_in = 1'b1;
                        state_in = tracking_ff ? ST_PRED : ST_INIT;
                     end
                     CMD_PREDICT: begin
                        if (tracking_ff) begin
                           state_in = ST_PRED;
                        end else begin
                           emit_in = 1'b1;
                        end
                     end
                     CMD_RESET: begin
                        tracking_in = 1'b0;
                        emit_in = 1'b1;
                     end
                     default: emit_in = 1'b1;
                  endcase
               end
            end
            ST_INIT: begin
               step.init = 1'b1;
               tracking_in = 1'b1;
               state_in = ST_PRED;
            end
            ST_PRED: begin
               step.predict = 1'b1;
               if (meas_cmd_ff) begin
                  state_in = ST_SDIV;
               end else begin
                  emit_in = 1'b1;
               end
            end
            ST_SDIV: begin
               div_start = 1'b1;
               state_in = ST_DIV;
            end
            ST_DIV: begin
               if (!busy_p && !busy_v) begin
                  if (innov == '0) begin
                     kp_in = '0;
                     kv_in = '0;
                  end else begin
                     kp_in = KP_W'(quo_p);
                     kv_in = ppv[OFF_W-1] ? -kv_mag : kv_mag;
                  end
                  state_in = ST_MUL;
               end
            end
            ST_MUL: begin
               step.mul = 1'b1;
               state_in = ST_CORR;
            end
            ST_CORR: begin
               step.correct = 1'b1;
               emit_in = 1'b1;
            end
            default: state_in = ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         emit_ff <= 1'b0;
         tracking_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pn_ff <= PROCESS_NOISE_RST;
         mn_ff <= MEASUREMENT_NOISE_RST;
         ie_ff <= INITIAL_ERROR_RST;
      end else begin
         state_ff <= state_in;
         emit_ff <= emit_in;
         tracking_ff <= tracking_in;
         rsp_valid_ff <= rsp_valid_in;
         pn_ff <= pn_in;
         mn_ff <= mn_in;
         ie_ff <= ie_in;
      end
      meas_cmd_ff <= meas_cmd_in;
      meas_ff <= meas_in;
      kp_ff <= kp_in;
      kv_ff <= kv_in;
      rsp_user_ff <= rsp_user_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE) && !emit_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser = rsp_user_ff;
   assign rsp_tdata = rsp_data_ff;

endmodule
`default_nettype wire

### rtl/ckt_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "corner_kalman_tracker_macros.svh"
module ckt_checker #(
   parameter int NUM_CORNERS = ckt_pkg::NUM_CORNERS_DEF
) (
   input wire logic                                       clock,
   input wire logic                                       reset,
   input wire logic                                       req_tvalid,
   input wire logic                                       req_tready,
   input wire logic                                       rsp_tvalid,
   input wire logic                                       rsp_tready,
   input wire logic [2*NUM_CORNERS*ckt_pkg::EST_W-1:0]    rsp_tdata,
   input wire logic                                       rsp_tuser
);
   import ckt_pkg::*;

   `CKT_ASSERT_NEXT(a_one_in_work, clock, reset, req_tvalid && req_tready, !req_tready)
   `CKT_ASSERT_SAME(a_idle_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata == '0)
   `CKT_ASSERT_SAME(a_reset_empty, clock, 1'b0, $past(reset), !rsp_tvalid)
   `CKT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)

endmodule

bind corner_kalman_tracker ckt_checker #(.NUM_CORNERS(NUM_CORNERS)) u_ckt_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser)
);
`default_nettype wire

### sim/corner_tracker_checker.sv
`timescale 1ns / 1ps
module corner_tracker_checker (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire logic                                        req_tvalid,
   input  wire logic                                        req_tready,
   input  wire logic [2*ckt_pkg::NUM_CORNERS_DEF*ckt_pkg::MEAS_W-1:0] req_tdata,
   input  wire logic [ckt_pkg::CMD_W-1:0]                   req_tuser,
   input  wire logic                                        rsp_tvalid,
   input  wire logic                                        rsp_tready,
   input  wire logic [2*ckt_pkg::NUM_CORNERS_DEF*ckt_pkg::EST_W-1:0] rsp_tdata,
   input  wire logic                                        rsp_tuser,
   input  wire logic                                        csr_we,
   input  wire logic [ckt_pkg::CSR_IDX_W-1:0]               csr_index,
   input  wire logic [ckt_pkg::CFG_W-1:0]                   csr_wdata,
   output int                                               fail_count,
   output int                                               pending_count,
   output int                                               rsp_seen
);
   import ckt_pkg::*;
   localparam int NC = NUM_CORNERS_DEF;
   localparam int LANES = 2 * NC;

   typedef struct {
      logic [LANES*EST_W-1:0] est;
      logic                   valid;
   } estimate_type;

   estimate_type expected_estimates[$];
   longint q_noise, r_noise, p_init;
   longint lane_pos[LANES];
   longint lane_vel[LANES];
   longint p_pp, p_pv, p_vv;
   bit tracking;

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint round16(longint v);
      longint t;
      t = v + 32768;
      if (t >= 0) return t >>> 16;
      return -((-t + 65535) >>> 16);
   endfunction

   function automatic longint gain_div(longint n, longint d);
      longint mag, g;
      mag = (n < 0 ? -n : n) <<< 16;
      g = (mag + d / 2) / d;
      if (g > (64'sd1 << 30)) g = 64'sd1 << 30;
      return n < 0 ? -g : g;
   endfunction

   task automatic advance_state();
      for (int i = 0; i < LANES; i++)
         lane_pos[i] = clip(lane_pos[i] + lane_vel[i], POS_LO, POS_HI);
      p_pp = clip(p_pp + 2 * p_pv + p_vv + q_noise, 0, DIAG_HI);
      p_pv = clip(p_pv + p_vv, OFF_LO, OFF_HI);
      p_vv = clip(p_vv + q_noise, 0, DIAG_HI);
   endtask

   task automatic track_request(input logic [CMD_W-1:0] cmd,
                                input logic [LANES*MEAS_W-1:0] meas);
      estimate_type e;
      longint z, err, s, kp, kv, pp, pv, vv;
      if (cmd == CMD_MEASURE) begin
         if (!tracking) begin
            for (int i = 0; i < LANES; i++) begin
               lane_pos[i] = longint'(meas[i*MEAS_W +: MEAS_W]);
               lane_vel[i] = 0;
            end
            p_pp = p_init;
            p_pv = 0;
            p_vv = p_init;
            tracking = 1;
         end
         advance_state();
         pp = p_pp;
         pv = p_pv;
         vv = p_vv;
         s = pp + r_noise;
         kp = 0;
         kv = 0;
         if (s > 0) begin
            kp = gain_div(pp, s);
            kv = gain_div(pv, s);
         end
         for (int i = 0; i < LANES; i++) begin
            z = longint'(meas[i*MEAS_W +: MEAS_W]);
            err = z - lane_pos[i];
            lane_pos[i] = clip(lane_pos[i] + round16(kp * err), POS_LO, POS_HI);
            lane_vel[i] = clip(lane_vel[i] + round16(kv * err), POS_LO, POS_HI);
         end
         p_pp = clip(pp - round16(kp * pp), 0, DIAG_HI);
         p_pv = clip(pv - round16(kp * pv), OFF_LO, OFF_HI);
         p_vv = clip(vv - round16(kv * pv), 0, DIAG_HI);
      end else if (cmd == CMD_PREDICT) begin
         if (tracking) advance_state();
      end else if (cmd == CMD_RESET) begin
         tracking = 0;
      end
      e.valid = tracking;
      for (int i = 0; i < LANES; i++)
         e.est[i*EST_W +: EST_W] = tracking ? EST_W'(clip(lane_pos[i], EST_LO, EST_HI)) : '0;
      expected_estimates.insert(expected_estimates.size(), e);
   endtask

   task automatic report(input string what, input longint got, input longint want);
      $display("Mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      rsp_seen = 0;
      tracking = 0;
   end

   always @(posedge clock) begin
      estimate_type e;
      if (reset) begin
         q_noise = longint'(PROCESS_NOISE_RST);
         r_noise = longint'(MEASUREMENT_NOISE_RST);
         p_init = longint'(INITIAL_ERROR_RST);
         tracking = 0;
         expected_estimates.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_PROCESS_NOISE:     q_noise = longint'(csr_wdata);
               REG_MEASUREMENT_NOISE: r_noise = longint'(csr_wdata);
               REG_INITIAL_ERROR:     p_init = longint'(csr_wdata);
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) track_request(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            rsp_seen++;
            if (expected_estimates.size() == 0) begin
               report("unexpected estimate", longint'(rsp_tdata[31:0]), 0);
            end else begin
               e = expected_estimates[0];
               expected_estimates.delete(0);
               if (rsp_tuser !== e.valid)
                  report("est_valid", longint'(rsp_tuser), longint'(e.valid));
               for (int i = 0; i < LANES; i++)
                  if (rsp_tdata[i*EST_W +: EST_W] !== e.est[i*EST_W +: EST_W])
                     report($sformatf("estimate lane %0d", i),
                            longint'(rsp_tdata[i*EST_W +: EST_W]),
                            longint'(e.est[i*EST_W +: EST_W]));
            end
         end
      end
      pending_count = expected_estimates.size();
   end
endmodule

### sim/tb_corner_kalman_tracker.sv
`timescale 1ns / 1ps
module tb_corner_kalman_tracker;
   import ckt_pkg::*;
   localparam int NC = NUM_CORNERS_DEF;
   localparam int LANES = 2 * NC;
   localparam int STALL_LIMIT = 20000;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [LANES*MEAS_W-1:0] req_tdata = '0;
   logic [CMD_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [LANES*EST_W-1:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_we = 0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0] csr_wdata = '0;
   int fail_count, pending_count, rsp_seen;
   int sent = 0;
   int idle_cycles = 0;
   bit quiet_phase = 0;
   bit hold_rsp = 0;

   always #1 clock = ~clock;

   corner_kalman_tracker DUT (.*);

   corner_tracker_checker u_checker (.*);

   always @(posedge clock) begin
      if (!reset && !((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))) begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Watchdog expired after %0d idle cycles", idle_cycles);
            $display("Regression FAIL");
            $finish;
         end
      end else begin
         idle_cycles = 0;
      end
   end

   // Result-side backpressure: random bursts, a long hold on request, none at the end.
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_tready <= 0;
            wait (!hold_rsp);
         end else if (quiet_phase || $urandom_range(0, 3) != 0) begin
            rsp_tready <= 1;
         end else begin
            n = $urandom_range(1, 6);
            rsp_tready <= 0;
            repeat (n) @(posedge clock);
            rsp_tready <= 1;
         end
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      @(posedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
   endtask

   task automatic drain();
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic send(input logic [CMD_W-1:0] cmd, input logic [LANES*MEAS_W-1:0] meas);
      if (!quiet_phase && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= cmd;
      req_tdata <= meas;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
   endtask

   function automatic logic [LANES*MEAS_W-1:0] track_meas(input int base, input int spread);
      logic [LANES*MEAS_W-1:0] m;
      for (int i = 0; i < LANES; i++)
         m[i*MEAS_W +: MEAS_W] = MEAS_W'(base + $urandom_range(0, spread));
      return m;
   endfunction

   function automatic logic [CMD_W-1:0] pick_cmd();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return CMD_MEASURE;
      if (r < 90) return CMD_PREDICT;
      if (r < 97) return CMD_RESET;
      return CMD_UNUSED;
   endfunction

   task automatic random_phase(input int count);
      int base;
      base = $urandom_range(0, 65535);
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(0, 9) == 0)
            send(pick_cmd(), {$urandom, $urandom, $urandom, $urandom});
         else begin
            base = base + $urandom_range(0, 64) - 32;
            if (base < 0) base = 0;
            if (base > 65535 - 64) base = 65535 - 64;
            send(pick_cmd(), track_meas(base, 64));
         end
      end
      req_tvalid <= 0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: idle commands, extremes, track start, saturation.
      send(CMD_PREDICT, '0);
      send(CMD_RESET, '0);
      send(CMD_UNUSED, '0);
      send(CMD_MEASURE, '0);
      send(CMD_MEASURE, '1);
      send(CMD_PREDICT, '1);
      send(CMD_UNUSED, '1);
      send(CMD_MEASURE, '0);
      send(CMD_MEASURE, '1);
      send(CMD_RESET, '1);
      send(CMD_MEASURE, {LANES{16'h5555}});
      send(CMD_MEASURE, {LANES{16'hAAAA}});
      for (int k = 0; k < 6; k++) send(CMD_PREDICT, '0);
      send(CMD_RESET, '0);
      req_tvalid <= 0;
      drain();

      // Measurement noise zero and all-ones extremes of every register.
      write_reg(REG_MEASUREMENT_NOISE, '0);
      write_reg(REG_PROCESS_NOISE, '0);
      write_reg(REG_INITIAL_ERROR, '0);
      send(CMD_MEASURE, track_meas(1000, 50));
      send(CMD_MEASURE, track_meas(1000, 50));
      send(CMD_PREDICT, '0);
      send(CMD_RESET, '0);
      req_tvalid <= 0;
      drain();
      write_reg(REG_PROCESS_NOISE, '1);
      write_reg(REG_MEASUREMENT_NOISE, '1);
      write_reg(REG_INITIAL_ERROR, '1);
      write_reg(REG_UNUSED, '1);
      random_phase(60);
      drain();

      // Long result stall while requests keep coming.
      hold_rsp = 1;
      fork
         random_phase(8);
         begin
            repeat (400) @(posedge clock);
            hold_rsp = 0;
         end
      join
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         write_reg(REG_PROCESS_NOISE, ph == 0 ? 24'd3277 : CFG_W'($urandom_range(0, 20000)));
         write_reg(REG_MEASUREMENT_NOISE, CFG_W'($urandom_range(1, 200000)));
         write_reg(REG_INITIAL_ERROR, CFG_W'($urandom_range(0, 300000)));
         random_phase(250);
         drain();
      end

      quiet_phase = 1;
      write_reg(REG_MEASUREMENT_NOISE, 24'd1);
      random_phase(150);
      drain();

      $display("Sent %0d requests and checked %0d estimates over 10 noise settings,",
               sent, rsp_seen);
      $display("including register extremes, idle commands and a long output stall.");
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

### files.f
+incdir+rtl
rtl/ckt_pkg.sv
rtl/ckt_lane.sv
rtl/ckt_cov.sv
rtl/ckt_div.sv
rtl/corner_kalman_tracker.sv
rtl/ckt_checker.sv
sim/corner_tracker_checker.sv
sim/tb_corner_kalman_tracker.sv
